/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK_RST(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/pdf_pkg.sv */
package pdf_pkg;

   localparam logic [7:0] SEPARATOR  = 8'h1E;
   localparam logic [7:0] COLON      = 8'h3A;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   // result queue between front and back
   localparam int QDEPTH     = 4;
   localparam int Q_PTR_BITS = $clog2(QDEPTH);
   localparam int Q_CNT_BITS = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_DATA = 2'd1,
      PH_SKIP = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_TRUNC = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       first_of_packet;
      logic       last_of_packet;
      status_type status;
      logic       run_last;
   } rsp_type;

   // how many results the front writes this cycle
   typedef struct packed {
      logic one;
      logic two;
   } push_type;

endpackage

/* rtl/pdf_front.sv */
module pdf_front #(
   parameter int LENGTH_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pdf_pkg::req_type  req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data,
   input  logic              space_ok,
   output pdf_pkg::push_type push,
   output pdf_pkg::rsp_type  res0,
   output pdf_pkg::rsp_type  res1
);

   localparam int VBITS = LENGTH_BITS + 4;

   logic                   mode_ff, mode_in;
   pdf_pkg::phase_type     phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] length_accum_ff, length_accum_in;
   logic                   digits_seen_ff, digits_seen_in;
   logic [LENGTH_BITS-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   held_first_ff, held_first_in;

   logic                   accept;
   logic                   csr_write;
   logic [7:0]             b;
   logic                   eop;
   logic                   is_digit;
   logic [VBITS-1:0]       accum_wide;
   logic [VBITS-1:0]       value_next;
   logic                   overflow;
   logic                   colon_ok;
   logic                   data_first;
   logic                   data_last;
   logic                   accum_zero;
   pdf_pkg::rsp_type       r0, r1;
   pdf_pkg::push_type      pu;

   assign csr_ready = 1'b1;
   // a register write takes the cycle, so no item is taken beside it
   assign req_ready = space_ok && !csr_valid;
   assign accept    = req_valid && req_ready;
   assign csr_write = csr_valid && csr_ready;
   assign b         = req_data.payload_byte;
   assign eop       = req_data.end_of_payload;

   // classification of the incoming byte
   assign is_digit   = (b >= pdf_pkg::DIGIT_ZERO) && (b <= pdf_pkg::DIGIT_NINE);
   assign accum_wide = {4'b0000, length_accum_ff};
   assign value_next = (accum_wide << 3) + (accum_wide << 1)
                     + {{(VBITS-4){1'b0}}, b[3:0]};
   assign overflow   = |value_next[VBITS-1:LENGTH_BITS];
   assign colon_ok   = (b == pdf_pkg::COLON) && digits_seen_ff;
   assign accum_zero = (length_accum_ff == '0);
   assign data_first = (bytes_left_ff == length_accum_ff);
   assign data_last  = (bytes_left_ff <= LENGTH_BITS'(1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (csr_write) begin
         phase_in = pdf_pkg::PH_LEN;
      end else if (accept && !mode_ff) begin
         unique case (phase_ff)
            pdf_pkg::PH_SKIP: begin
               if (eop) phase_in = pdf_pkg::PH_LEN;
            end
            pdf_pkg::PH_DATA: begin
               if (data_last || eop) phase_in = pdf_pkg::PH_LEN;
            end
            pdf_pkg::PH_LEN: begin
               priority if (is_digit) begin
                  if (overflow) phase_in = eop ? pdf_pkg::PH_LEN : pdf_pkg::PH_SKIP;
               end else if (colon_ok) begin
                  if (!accum_zero && !eop) phase_in = pdf_pkg::PH_DATA;
               end else begin
                  phase_in = eop ? pdf_pkg::PH_LEN : pdf_pkg::PH_SKIP;
               end
            end
            default: phase_in = pdf_pkg::PH_LEN;
         endcase
      end
   end

   // results and data state
   always_comb begin
      mode_in         = mode_ff;
      length_accum_in = length_accum_ff;
      digits_seen_in  = digits_seen_ff;
      bytes_left_in   = bytes_left_ff;
      held_byte_in    = held_byte_ff;
      held_valid_in   = held_valid_ff;
      held_first_in   = held_first_ff;
      r0              = '0;
      r1              = '0;
      pu              = '0;
      if (csr_write) begin
         mode_in         = csr_data;
         length_accum_in = '0;
         digits_seen_in  = 1'b0;
         bytes_left_in   = '0;
         held_byte_in    = '0;
         held_valid_in   = 1'b0;
         held_first_in   = 1'b0;
      end else if (accept && mode_ff) begin
         if (b == pdf_pkg::SEPARATOR) begin
            if (held_valid_ff) begin
               r0     = '{held_byte_ff, held_first_ff, 1'b1, pdf_pkg::STATUS_OK, 1'b0};
               pu.one = 1'b1;
            end
            held_byte_in  = '0;
            held_valid_in = 1'b0;
            held_first_in = 1'b0;
         end else begin
            if (held_valid_ff) begin
               r0     = '{held_byte_ff, held_first_ff, 1'b0, pdf_pkg::STATUS_OK, 1'b0};
               pu.one = 1'b1;
            end
            if (eop) begin
               if (held_valid_ff) begin
                  r1     = '{b, 1'b0, 1'b1, pdf_pkg::STATUS_OK, 1'b0};
                  pu.two = 1'b1;
               end else begin
                  r0     = '{b, 1'b1, 1'b1, pdf_pkg::STATUS_OK, 1'b0};
                  pu.one = 1'b1;
               end
               held_byte_in  = '0;
               held_valid_in = 1'b0;
               held_first_in = 1'b0;
            end else begin
               held_byte_in  = b;
               held_first_in = !held_valid_ff;
               held_valid_in = 1'b1;
            end
         end
      end else if (accept) begin
         unique case (phase_ff)
            pdf_pkg::PH_SKIP: begin
            end
            pdf_pkg::PH_DATA: begin
               r0     = '{b, data_first, data_last, pdf_pkg::STATUS_OK, 1'b0};
               pu.one = 1'b1;
               bytes_left_in = data_last ? '0 : bytes_left_ff - LENGTH_BITS'(1);
               if (data_last) begin
                  length_accum_in = '0;
               end else if (eop) begin
                  r1     = '{8'h00, 1'b0, 1'b0, pdf_pkg::STATUS_TRUNC, 1'b0};
                  pu.two = 1'b1;
                  length_accum_in = '0;
                  bytes_left_in   = '0;
               end
            end
            pdf_pkg::PH_LEN: begin
               priority if (is_digit && !overflow) begin
                  length_accum_in = value_next[LENGTH_BITS-1:0];
                  digits_seen_in  = 1'b1;
                  if (eop) begin
                     r0     = '{8'h00, 1'b0, 1'b0, pdf_pkg::STATUS_TRUNC, 1'b0};
                     pu.one = 1'b1;
                     length_accum_in = '0;
                     digits_seen_in  = 1'b0;
                  end
               end else if (!is_digit && colon_ok) begin
                  digits_seen_in = 1'b0;
                  if (!accum_zero) begin
                     if (eop) begin
                        r0     = '{8'h00, 1'b0, 1'b0, pdf_pkg::STATUS_TRUNC, 1'b0};
                        pu.one = 1'b1;
                        length_accum_in = '0;
                     end else begin
                        bytes_left_in = length_accum_ff;
                     end
                  end
               end else begin
                  // bad prefix
                  r0     = '{8'h00, 1'b0, 1'b0, pdf_pkg::STATUS_BAD, 1'b0};
                  pu.one = 1'b1;
                  length_accum_in = '0;
                  digits_seen_in  = 1'b0;
                  bytes_left_in   = '0;
               end
            end
            default: begin
            end
         endcase
      end
      // mark the last result of this item
      if (pu.two) begin
         r1.run_last = 1'b1;
      end else if (pu.one) begin
         r0.run_last = 1'b1;
      end
   end

   assign push = pu;
   assign res0 = r0;
   assign res1 = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b1;
         phase_ff        <= pdf_pkg::PH_LEN;
         length_accum_ff <= '0;
         digits_seen_ff  <= 1'b0;
         bytes_left_ff   <= '0;
         held_byte_ff    <= '0;
         held_valid_ff   <= 1'b0;
         held_first_ff   <= 1'b0;
      end else begin
         mode_ff         <= mode_in;
         phase_ff        <= phase_in;
         length_accum_ff <= length_accum_in;
         digits_seen_ff  <= digits_seen_in;
         bytes_left_ff   <= bytes_left_in;
         held_byte_ff    <= held_byte_in;
         held_valid_ff   <= held_valid_in;
         held_first_ff   <= held_first_in;
      end
   end

endmodule

/* rtl/pdf_queue.sv */
module pdf_queue (
   input  logic              clock,
   input  logic              reset,
   input  pdf_pkg::push_type push,
   input  pdf_pkg::rsp_type  wr_data0,
   input  pdf_pkg::rsp_type  wr_data1,
   input  logic              pop,
   output logic              space_ok,
   output logic              not_empty,
   output pdf_pkg::rsp_type  rd_data
);

   pdf_pkg::rsp_type mem [pdf_pkg::QDEPTH];

   logic [pdf_pkg::Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pdf_pkg::Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pdf_pkg::Q_CNT_BITS-1:0] count_ff, count_in;
   logic [1:0]                     push_cnt;

   assign push_cnt  = {1'b0, push.one} + {1'b0, push.two};
   assign wr_ptr_in = wr_ptr_ff + pdf_pkg::Q_PTR_BITS'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + pdf_pkg::Q_PTR_BITS'(pop);
   assign count_in  = count_ff + pdf_pkg::Q_CNT_BITS'(push_cnt)
                    - pdf_pkg::Q_CNT_BITS'(pop);

   assign space_ok  = count_ff <= pdf_pkg::Q_CNT_BITS'(pdf_pkg::QDEPTH - 2);
   assign not_empty = count_ff != '0;
   assign rd_data   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.one) mem[wr_ptr_ff] <= wr_data0;
      if (push.two) mem[wr_ptr_ff + pdf_pkg::Q_PTR_BITS'(1)] <= wr_data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/pdf_back.sv */
module pdf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             not_empty,
   input  pdf_pkg::rsp_type rd_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdf_pkg::rsp_type rsp_data
);

   logic             rsp_valid_ff, rsp_valid_in;
   pdf_pkg::rsp_type rsp_data_ff;

   assign pop          = not_empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_data_ff <= rd_data;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/payload_deframer.sv */
// channel   direction  carries
// req_      in         payload_byte, end_of_payload
// rsp_      out        packet_byte, first/last marks, status, run_last
// csr_      in         framing_mode (write only)
//
// one item accepted per cycle while req_ready is high; each item is classified in the cycle it is taken
// an item gives zero to two results; the back end sends one result per cycle while rsp_ready is high,
// so the sustained rate is one item per cycle while items give at most one result
// req_ready drops when the four-entry result queue has fewer than two free slots
// or while a register write is offered
// rsp_valid rises when a result moves from the queue into the output register; reset is synchronous, no clearing pass
module payload_deframer #(
   parameter int LENGTH_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   pdf_pkg::push_type push;
   pdf_pkg::rsp_type  res0;
   pdf_pkg::rsp_type  res1;
   pdf_pkg::rsp_type  rd_data;
   logic              space_ok;
   logic              not_empty;
   logic              pop;

   pdf_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .space_ok  (space_ok),
      .push      (push),
      .res0      (res0),
      .res1      (res1)
   );

   pdf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data0  (res0),
      .wr_data1  (res1),
      .pop       (pop),
      .space_ok  (space_ok),
      .not_empty (not_empty),
      .rd_data   (rd_data)
   );

   pdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .rd_data   (rd_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/pdf_checker.sv */
`include "assert_macros.svh"

module pdf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input pdf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pdf_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready,
   input logic             csr_data
);

   // stalled result holds
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // error results carry no byte and no marks
   `ASSERT_CLK_RST(a_err_clean, clock, reset, rsp_valid && rsp_data.status != pdf_pkg::STATUS_OK |-> rsp_data.packet_byte == 8'h00 && !rsp_data.first_of_packet && !rsp_data.last_of_packet, "error result not clean")

   // a bad prefix is the only result of its item
   `ASSERT_CLK_RST(a_bad_alone, clock, reset, rsp_valid && rsp_data.status == pdf_pkg::STATUS_BAD |-> rsp_data.run_last, "bad prefix not run_last")

   // nothing leaves the block straight after reset
   `ASSERT_CLK(a_reset_quiet, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind payload_deframer pdf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_data  (csr_data)
);
